// ===== rtl/four_level_page_walk_top_defines.svh =====
// ---------------------------------------------------------------------------
// four_level_page_walk_top_defines.svh
// Assertion macros for the page walker RTL.
// ---------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_WALK_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALK_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FLPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define FLPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/flpw_pkg.sv =====
// ---------------------------------------------------------------------------
// flpw_pkg
// Types, codes and constants shared by the four-level page walker.
// ---------------------------------------------------------------------------
package flpw_pkg;

	localparam int PHYS_ADDR_BITS_DEF = 16;

	localparam int WORD_ADDR_W = 13;
	localparam int ENTRY_W     = 64;
	localparam int VA_W        = 48;
	localparam int ROOT_W      = 4;
	localparam int LEVEL_W     = 2;
	localparam int IDX_W       = 9;
	localparam int PAGE_OFS_W  = 12;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_XLATE = 1'b1
	} cmd_t;

	localparam logic [LEVEL_W-1:0] MISS_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] MISS_L1   = 2'd1;
	localparam logic [LEVEL_W-1:0] MISS_L2   = 2'd2;
	localparam logic [LEVEL_W-1:0] MISS_L3   = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK1,
		ST_CHK2,
		ST_CHK3,
		ST_LEAF,
		ST_WRES
	} state_t;

	typedef enum logic [2:0] {
		ASEL_CLR,
		ASEL_WR,
		ASEL_ROOT,
		ASEL_L1,
		ASEL_L2,
		ASEL_L3
	} asel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_MISS,
		RES_LEAF
	} res_kind_t;

	typedef struct packed {
		logic                ram_we;
		logic                ram_re;
		asel_t               asel;
		logic                capture;
		logic                clr_step;
		logic                res_load;
		res_kind_t           res_kind;
		logic [LEVEL_W-1:0]  miss_level;
	} dp_cmd_t;

	typedef struct packed {
		logic entry_zero;
		logic slot_free;
		logic clr_last;
	} dp_sts_t;

endpackage

// ===== rtl/flpw_ifs.sv =====
// ---------------------------------------------------------------------------
// flpw_ifs
// Valid/ready channels of the page walker: request, response, configuration.
// ---------------------------------------------------------------------------
interface flpw_req_if
	import flpw_pkg::*;
();
	logic                   valid;
	logic                   ready;
	cmd_t                   cmd;
	logic [WORD_ADDR_W-1:0] word_addr;
	logic [ENTRY_W-1:0]     word_data;
	logic [VA_W-1:0]        vaddr;

	modport source (output valid, cmd, word_addr, word_data, vaddr, input ready);
	modport sink (input valid, cmd, word_addr, word_data, vaddr, output ready);
endinterface

interface flpw_rsp_if
	import flpw_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [ENTRY_W-1:0] raw_entry;
	logic [ENTRY_W-1:0] phys_addr;
	logic [LEVEL_W-1:0] missing_level;

	modport source (output valid, raw_entry, phys_addr, missing_level, input ready);
	modport sink (input valid, raw_entry, phys_addr, missing_level, output ready);
endinterface

interface flpw_cfg_if
	import flpw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] root_frame;

	modport source (output valid, root_frame, input ready);
	modport sink (input valid, root_frame, output ready);
endinterface

// ===== rtl/flpw_ram.sv =====
// ---------------------------------------------------------------------------
// flpw_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
module flpw_ram #(
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	localparam longint unsigned DEPTH = 64'd1 << ADDR_W;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/flpw_dp.sv =====
// ---------------------------------------------------------------------------
// flpw_dp
// Walker datapath: root register, table RAM, address build, result register.
// ---------------------------------------------------------------------------
module flpw_dp
	import flpw_pkg::*;
#(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ROOT_W-1:0]      cfg_root,
	input  logic [WORD_ADDR_W-1:0] in_word_addr,
	input  logic [ENTRY_W-1:0]     in_word_data,
	input  logic [VA_W-1:0]        in_vaddr,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [ENTRY_W-1:0]     out_raw_entry,
	output logic [ENTRY_W-1:0]     out_phys_addr,
	output logic [LEVEL_W-1:0]     out_missing_level
);

	localparam int AW = PHYS_ADDR_BITS - 3;

	logic [ROOT_W-1:0]  root_q;
	logic [VA_W-1:0]    va_q;
	logic [AW-1:0]      clr_cnt_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] raw_q;
	logic [ENTRY_W-1:0] phys_q;
	logic [LEVEL_W-1:0] miss_q;

	logic [AW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [IDX_W-1:0]   lvl_idx;
	logic [63:0]        root_word;
	logic [63:0]        wr_word;
	logic               frame_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_we) begin
			root_q <= cfg_root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q <= in_vaddr;
		end
	end

	// Word indices wrap modulo the memory depth, whichever side is wider.
	assign root_word = {{(64 - ROOT_W - IDX_W){1'b0}}, root_q,
		in_vaddr[VA_W-1 -: IDX_W]};
	assign wr_word   = {{(64 - WORD_ADDR_W){1'b0}}, in_word_addr};

	always_comb begin
		unique case (cmd.asel)
			ASEL_L1: lvl_idx = va_q[38:30];
			ASEL_L2: lvl_idx = va_q[29:21];
			default: lvl_idx = va_q[20:12];
		endcase
	end

	// A pointer entry supplies the frame bits that lie inside the memory.
	always_comb begin
		unique case (cmd.asel)
			ASEL_CLR:  ram_addr = clr_cnt_q;
			ASEL_WR:   ram_addr = wr_word[AW-1:0];
			ASEL_ROOT: ram_addr = root_word[AW-1:0];
			default:   ram_addr = {ram_rdata[PHYS_ADDR_BITS-1:PAGE_OFS_W], lvl_idx};
		endcase
	end

	assign ram_wdata = cmd.clr_step ? '0 : in_word_data;

	flpw_ram #(
		.WIDTH  (ENTRY_W),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.re    (cmd.ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign frame_nz = |ram_rdata[ENTRY_W-1:PAGE_OFS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_LEAF: begin
					raw_q  <= ram_rdata;
					phys_q <= frame_nz ?
						{ram_rdata[ENTRY_W-1:PAGE_OFS_W], va_q[PAGE_OFS_W-1:0]} : '0;
					miss_q <= MISS_NONE;
				end
				RES_MISS: begin
					raw_q  <= '0;
					phys_q <= '0;
					miss_q <= cmd.miss_level;
				end
				default: begin
					raw_q  <= '0;
					phys_q <= '0;
					miss_q <= MISS_NONE;
				end
			endcase
		end
	end

	assign sts.entry_zero = (ram_rdata == '0);
	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.clr_last   = (clr_cnt_q == '1);

	assign out_valid         = out_valid_q;
	assign out_raw_entry     = raw_q;
	assign out_phys_addr     = phys_q;
	assign out_missing_level = miss_q;

endmodule

// ===== rtl/flpw_ctrl.sv =====
// ---------------------------------------------------------------------------
// flpw_ctrl
// Walker controller: clearing pass, request accept, level sequencing.
// ---------------------------------------------------------------------------
module flpw_ctrl
	import flpw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  cmd_t    in_cmd,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.asel       = ASEL_L3;
		cmd.res_kind   = RES_ZERO;
		cmd.miss_level = MISS_NONE;

		unique case (state_q)
			ST_CLEAR: begin
				cmd.ram_we   = 1'b1;
				cmd.clr_step = 1'b1;
				cmd.asel     = ASEL_CLR;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_cmd == CMD_WRITE) begin
						cmd.ram_we = 1'b1;
						cmd.asel   = ASEL_WR;
						state_d    = ST_WRES;
					end else begin
						cmd.ram_re = 1'b1;
						cmd.asel   = ASEL_ROOT;
						state_d    = ST_CHK1;
					end
				end
			end
			// While a zero entry waits for the result slot no read is issued, so the RAM
			// output holds the entry under test.
			ST_CHK1: begin
				if (!sts.entry_zero) begin
					cmd.ram_re = 1'b1;
					cmd.asel   = ASEL_L1;
					state_d    = ST_CHK2;
				end else if (sts.slot_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_kind   = RES_MISS;
					cmd.miss_level = MISS_L1;
					state_d        = ST_IDLE;
				end
			end
			ST_CHK2: begin
				if (!sts.entry_zero) begin
					cmd.ram_re = 1'b1;
					cmd.asel   = ASEL_L2;
					state_d    = ST_CHK3;
				end else if (sts.slot_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_kind   = RES_MISS;
					cmd.miss_level = MISS_L2;
					state_d        = ST_IDLE;
				end
			end
			ST_CHK3: begin
				if (!sts.entry_zero) begin
					cmd.ram_re = 1'b1;
					cmd.asel   = ASEL_L3;
					state_d    = ST_LEAF;
				end else if (sts.slot_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_kind   = RES_MISS;
					cmd.miss_level = MISS_L3;
					state_d        = ST_IDLE;
				end
			end
			ST_LEAF: begin
				if (sts.slot_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_LEAF;
					state_d      = ST_IDLE;
				end
			end
			ST_WRES: begin
				if (sts.slot_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ZERO;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/four_level_page_walk_top.sv =====
// ---------------------------------------------------------------------------
// four_level_page_walk_top
// Four-level page table walker over a private table memory.
// ---------------------------------------------------------------------------
// After reset the block sweeps its table RAM to zero, one word a cycle, over
// all 2^(PHYS_ADDR_BITS-3) words (8192 at the default); req.ready stays low
// until the sweep is done, while configuration beats are taken at any time.
// A write beat stores one table word and returns an all-zero result once the
// result slot is free. A translate beat walks the four levels with one read
// of the single-port table RAM per level, each later read address built from
// the previous entry; a full walk runs CHK1, CHK2, CHK3 and LEAF before IDLE
// takes the next beat, and a walk that finds a zero entry at level k (1 to 3)
// returns to IDLE from CHKk. Results sit in an output register, and a stall
// on rsp holds the walker only when it has a finished result to place.
// ---------------------------------------------------------------------------
`include "four_level_page_walk_top_defines.svh"

module four_level_page_walk_top
	import flpw_pkg::*;
#(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	flpw_cfg_if.sink   cfg,
	flpw_req_if.sink   req,
	flpw_rsp_if.source rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;
	logic    rsp_miss;
	logic    rsp_zero;

	assign cfg.ready = 1'b1;

	flpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (req.ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	flpw_dp #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg.valid),
		.cfg_root          (cfg.root_frame),
		.in_word_addr      (req.word_addr),
		.in_word_data      (req.word_data),
		.in_vaddr          (req.vaddr),
		.cmd               (dp_cmd),
		.sts               (dp_sts),
		.out_ready         (rsp.ready),
		.out_valid         (rsp.valid),
		.out_raw_entry     (rsp.raw_entry),
		.out_phys_addr     (rsp.phys_addr),
		.out_missing_level (rsp.missing_level)
	);

	assign rsp_miss = rsp.valid && (rsp.missing_level != MISS_NONE);
	assign rsp_zero = (rsp.raw_entry == '0) && (rsp.phys_addr == '0);

	`FLPW_ASSERT_IMP(a_no_accept_in_clear, dp_cmd.clr_step, !req.ready, "beat accepted during clear")
	`FLPW_ASSERT_IMP(a_load_needs_slot, dp_cmd.res_load, dp_sts.slot_free, "result overwrote a beat")
	`FLPW_ASSERT_IMP(a_ram_one_access, dp_cmd.ram_we, !dp_cmd.ram_re, "RAM read and written together")
	`FLPW_ASSERT_IMP(a_miss_is_zero, rsp_miss, rsp_zero, "missing walk with nonzero fields")

endmodule

// ===== tb/sv/four_level_page_walk_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_level_page_walk_top_tb
// Self-checking bench for the four-level page walker. It loads page tables
// through write beats and translates addresses against a shadow copy of the
// table memory. Each response beat is checked against the oldest prediction.
// Both channels idle at random, and the root frame changes between phases.
// ---------------------------------------------------------------------------
module four_level_page_walk_top_tb;
	import flpw_pkg::*;

	localparam int PHYS_BITS     = PHYS_ADDR_BITS_DEF;
	localparam int FRAME_W       = PHYS_BITS - PAGE_OFS_W;
	localparam int MEM_WORDS     = 1 << (PHYS_BITS - 3);
	localparam int TOP_SHIFT     = PAGE_OFS_W + 3 * IDX_W;
	localparam int LATENCY_SLACK = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_PRINTS    = 100;
	localparam longint TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [ENTRY_W-1:0] raw_entry;
		logic [ENTRY_W-1:0] phys_addr;
		logic [LEVEL_W-1:0] missing_level;
	} walk_result_t;

	logic clk;
	logic arst_n;
	bit   steady;
	bit   rsp_hold;

	logic [ENTRY_W-1:0] table_shadow [MEM_WORDS];
	logic [ROOT_W-1:0]  root_shadow;
	walk_result_t       pending_walks [$];
	int unsigned        items_sent;
	int unsigned        mismatch_count;

	flpw_cfg_if cfg ();
	flpw_req_if req ();
	flpw_rsp_if rsp ();

	four_level_page_walk_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Computes what one accepted beat returns and applies it to the shadow tables.
	function automatic walk_result_t walk_page_tables(cmd_t c, logic [WORD_ADDR_W-1:0] wa,
			logic [ENTRY_W-1:0] wd, logic [VA_W-1:0] va);
		walk_result_t       r;
		logic [FRAME_W-1:0] frame;
		logic [IDX_W-1:0]   idx;
		logic [ENTRY_W-1:0] entry;
		r = '0;
		r.missing_level = MISS_NONE;
		if (c == CMD_WRITE) begin
			table_shadow[wa] = wd;
			return r;
		end
		frame = root_shadow;
		for (int lvl = 0; lvl < 3; lvl++) begin
			idx = IDX_W'(va >> (TOP_SHIFT - IDX_W * lvl));
			entry = table_shadow[{frame, idx}];
			if (entry == '0) begin
				case (lvl)
					0: r.missing_level = MISS_L1;
					1: r.missing_level = MISS_L2;
					default: r.missing_level = MISS_L3;
				endcase
				return r;
			end
			// Pointer bits above the memory size drop out, so the table wraps.
			frame = entry[PAGE_OFS_W +: FRAME_W];
		end
		entry = table_shadow[{frame, va[PAGE_OFS_W +: IDX_W]}];
		r.raw_entry = entry;
		if (entry[ENTRY_W-1:PAGE_OFS_W] != '0)
			r.phys_addr = {entry[ENTRY_W-1:PAGE_OFS_W], va[PAGE_OFS_W-1:0]};
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [ENTRY_W-1:0] got,
			logic [ENTRY_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Offers one beat, idling now and then, and records its prediction once taken.
	task automatic send_item(cmd_t c, logic [WORD_ADDR_W-1:0] wa, logic [ENTRY_W-1:0] wd,
			logic [VA_W-1:0] va);
		while (!steady && $urandom_range(0, 99) < 8) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.cmd       <= c;
		req.word_addr <= wa;
		req.word_data <= wd;
		req.vaddr     <= va;
		do @(posedge clk); while (!req.ready);
		pending_walks.push_back(walk_page_tables(c, wa, wd, va));
		items_sent++;
	endtask

	task automatic write_entry(logic [WORD_ADDR_W-1:0] wa, logic [ENTRY_W-1:0] wd);
		send_item(CMD_WRITE, wa, wd, VA_W'({$urandom, $urandom}));
	endtask

	task automatic translate(logic [VA_W-1:0] va);
		send_item(CMD_XLATE, WORD_ADDR_W'($urandom), {$urandom, $urandom}, va);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_walks.size() != 0);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	task automatic set_root(logic [ROOT_W-1:0] frame);
		drain();
		cfg.valid      <= 1'b1;
		cfg.root_frame <= frame;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		root_shadow = frame;
	endtask

	// A table pointer to the given frame, with random flags and high bits.
	function automatic logic [ENTRY_W-1:0] pointer_to(logic [FRAME_W-1:0] frame);
		logic [ENTRY_W-1:0] e;
		e = {$urandom, $urandom};
		e[PAGE_OFS_W +: FRAME_W] = frame;
		if (e == '0)
			e[0] = 1'b1;
		return e;
	endfunction

	// Builds a full four-level chain for a random address, then translates it.
	// A broken chain gets a zero entry at one level, and its probes may miss.
	task automatic map_and_translate(bit broken);
		logic [VA_W-1:0]        va;
		logic [VA_W-1:0]        probe;
		logic [FRAME_W-1:0]     frames [3];
		logic [WORD_ADDR_W-1:0] slots [4];
		logic [ENTRY_W-1:0]     words [4];
		int                     cut;
		va = VA_W'({$urandom, $urandom});
		for (int i = 0; i < 3; i++)
			frames[i] = FRAME_W'($urandom);
		slots[0] = {root_shadow, va[TOP_SHIFT +: IDX_W]};
		for (int i = 1; i < 4; i++)
			slots[i] = {frames[i-1], va[TOP_SHIFT - IDX_W * i +: IDX_W]};
		for (int i = 0; i < 3; i++)
			words[i] = pointer_to(frames[i]);
		words[3] = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: words[3] = '0;
			1: words[3][ENTRY_W-1:PAGE_OFS_W] = '0;
			default: ;
		endcase
		cut = broken ? $urandom_range(0, 3) : -1;
		for (int i = 0; i < 4; i++)
			write_entry(slots[i], (i == cut) ? '0 : words[i]);
		repeat ($urandom_range(1, 3)) begin
			probe = {va[VA_W-1:PAGE_OFS_W], PAGE_OFS_W'($urandom)};
			if (broken && $urandom_range(0, 1))
				probe[$urandom_range(PAGE_OFS_W, VA_W-1)] ^= 1'b1;
			translate(probe);
		end
	endtask

	// Hand-built tables: a miss at every level, a zero leaf, a leaf without
	// frame bits, an all-ones leaf, pointers with bits above the memory, and
	// the first and last words of the table memory.
	task automatic test_directed_walks();
		logic [VA_W-1:0] va;
		set_root('0);
		va = {9'd1, 9'd2, 9'd3, 9'd4, 12'hABC};
		translate(va);
		write_entry({4'd0, 9'd1}, 64'h8000_0000_0000_3067);
		translate(va);
		write_entry({4'd3, 9'd2}, 64'h0000_0000_0001_7000);
		translate(va);
		write_entry({4'd7, 9'd3}, 64'h0000_0000_0000_9001);
		translate(va);
		write_entry({4'd9, 9'd4}, 64'h0000_0000_0000_0FFF);
		translate(va);
		write_entry({4'd9, 9'd4}, '1);
		translate(va);
		translate({va[VA_W-1:PAGE_OFS_W], 12'h000});
		translate({va[VA_W-1:PAGE_OFS_W], 12'hFFF});
		write_entry({4'd3, 9'd2}, '0);
		translate(va);
		send_item(CMD_WRITE, '0, '1, '1);
		send_item(CMD_WRITE, '1, '0, '1);
		send_item(CMD_XLATE, '1, '1, '0);
		send_item(CMD_XLATE, '0, '0, '1);
	endtask

	task automatic test_random_walks(logic [ROOT_W-1:0] frame, int unsigned count, bit quiet);
		int unsigned target;
		int unsigned pick;
		set_root(frame);
		steady <= quiet;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				map_and_translate(1'b0);
			else if (pick < 85)
				map_and_translate(1'b1);
			else
				send_item(cmd_t'(1'($urandom)), WORD_ADDR_W'($urandom), {$urandom, $urandom},
					VA_W'({$urandom, $urandom}));
		end
	endtask

	// The receiver holds off long enough for the walker to fill and stall its input.
	task automatic test_output_stall();
		drain();
		rsp_hold <= 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold <= 1'b0;
			end
			begin
				repeat (3) map_and_translate(1'b0);
				req.valid <= 1'b0;
			end
		join
	endtask

	always @(posedge clk)
		rsp.ready <= !rsp_hold && (steady || $urandom_range(0, 99) >= 8);

	always @(posedge clk) begin : check_results
		walk_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_walks.size() == 0) begin
				report_mismatch("response beat with nothing pending", rsp.raw_entry, '0);
			end else begin
				want = pending_walks.pop_front();
				if (rsp.raw_entry !== want.raw_entry)
					report_mismatch("raw_entry", rsp.raw_entry, want.raw_entry);
				if (rsp.phys_addr !== want.phys_addr)
					report_mismatch("phys_addr", rsp.phys_addr, want.phys_addr);
				if (rsp.missing_level !== want.missing_level)
					report_mismatch("missing_level", ENTRY_W'(rsp.missing_level),
						ENTRY_W'(want.missing_level));
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		steady         <= 1'b0;
		rsp_hold       <= 1'b0;
		req.valid      <= 1'b0;
		req.cmd        <= CMD_WRITE;
		req.word_addr  <= '0;
		req.word_data  <= '0;
		req.vaddr      <= '0;
		cfg.valid      <= 1'b0;
		cfg.root_frame <= '0;
		for (int i = 0; i < MEM_WORDS; i++)
			table_shadow[i] = '0;
		root_shadow    = '0;
		items_sent     = 0;
		mismatch_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_walks();
		test_random_walks('1, 400, 1'b1);
		test_random_walks(ROOT_W'($urandom), 420, 1'b0);
		test_output_stall();
		test_random_walks('0, 400, 1'b0);
		test_random_walks(ROOT_W'($urandom), 400, 1'b0);
		drain();

		if (mismatch_count == 0)
			$display("four_level_page_walk_top regression: pass");
		else
			$display("four_level_page_walk_top regression: fail");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("four_level_page_walk_top regression: fail");
		$finish;
	end

endmodule
